FILE: hw/rtl/lcrs_pkg.sv
// Package for the lattice coefficient rejection sampler.
// Holds the constants, register indexes, queue entry type and the small-mode table.
// Has no dependencies.
package lcrs_pkg;

    localparam int COEFF_COUNT = 256;

    localparam logic [22:0] WORD_MASK   = 23'h7FFFFF;
    localparam logic [3:0]  NIBBLE_REJ  = 4'd15;

    localparam logic [0:0]  MODE_RESET    = 1'b0;
    localparam logic [23:0] MODULUS_RESET = 24'd8380417;
    localparam logic [8:0]  TARGET_RESET  = 9'd256;

    typedef enum logic [1:0] {
        CFG_MODE    = 2'd0,
        CFG_MODULUS = 2'd1,
        CFG_TARGET  = 2'd2
    } cfg_index_t;

    typedef enum logic {
        MODE_UNIFORM = 1'b0,
        MODE_SMALL   = 1'b1
    } sample_mode_t;

    typedef struct packed {
        logic               pair;
        logic signed [23:0] coef0;
        logic [7:0]         pos0;
        logic               last0;
        logic signed [23:0] coef1;
        logic [7:0]         pos1;
        logic               last1;
    } lcrs_entry_t;

    function automatic logic signed [23:0] small_coef(input logic [3:0] t);
        logic signed [23:0] c;
        unique case (t)
            4'd0, 4'd5, 4'd10:  c = 24'sd2;
            4'd1, 4'd6, 4'd11:  c = 24'sd1;
            4'd2, 4'd7, 4'd12:  c = 24'sd0;
            4'd3, 4'd8, 4'd13:  c = -24'sd1;
            default:            c = -24'sd2;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/lcrs_front.sv
// Front part of the sampler: configuration registers, byte acceptance and classification.
// An accepted byte yielding coefficients pushes a queue entry of up to two. Uses lcrs_pkg.
module lcrs_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [23:0]          cfg_data,
    input  logic                 in_valid,
    input  logic                 q_full,
    input  logic [7:0]           random_byte,
    input  logic                 start_req,
    input  logic                 buffer_end,
    output logic                 push,
    output lcrs_pkg::lcrs_entry_t push_entry
);
    import lcrs_pkg::*;

    logic        mode_reg;
    logic [23:0] modulus_reg;
    logic [8:0]  target_reg;

    logic [8:0]  count_reg,  count_next;
    logic [1:0]  phase_reg,  phase_next;
    logic [15:0] pw_reg,     pw_next;

    logic        accept;
    logic [8:0]  eff_target;
    logic [8:0]  cnt0, cnt1;
    logic [1:0]  phase0;
    logic [15:0] pw0;
    logic        active;
    logic [22:0] word;
    logic        ok_word, ok_lo, ok_hi;
    logic [3:0]  lo, hi;
    logic [1:0]  n_emit;

    assign accept = in_valid && !q_full;
    assign lo = random_byte[3:0];
    assign hi = random_byte[7:4];

    always_comb
    begin
        eff_target = (target_reg > 9'(COEFF_COUNT)) ? 9'(COEFF_COUNT) : target_reg;
        cnt0   = start_req ? 9'd0 : count_reg;
        phase0 = start_req ? 2'd0 : phase_reg;
        pw0    = start_req ? 16'd0 : pw_reg;
        active = cnt0 < eff_target;
        word   = {random_byte[6:0], pw0} & WORD_MASK;
        ok_word = 1'b0;
        ok_lo   = 1'b0;
        ok_hi   = 1'b0;
        phase_next = phase0;
        pw_next    = pw0;
        n_emit     = 2'd0;
        push_entry = '0;
        if (active)
        begin
            if (mode_reg == MODE_UNIFORM)
            begin
                if (phase0 >= 2'd2)
                begin
                    phase_next = 2'd0;
                    pw_next    = 16'd0;
                    ok_word    = {1'b0, word} < modulus_reg;
                end
                else
                begin
                    if (phase0 == 2'd0)
                    begin
                        pw_next = {pw0[15:8], random_byte};
                    end
                    else
                    begin
                        pw_next = {random_byte, pw0[7:0]};
                    end
                    phase_next = phase0 + 2'd1;
                end
            end
            else
            begin
                ok_lo = lo < NIBBLE_REJ;
            end
        end
        cnt1  = cnt0 + {8'd0, ok_lo};
        ok_hi = active && (mode_reg == MODE_SMALL) && (cnt1 < eff_target) && (hi < NIBBLE_REJ);
        n_emit = {1'b0, ok_word | ok_lo} + {1'b0, ok_hi};

        push_entry.pair  = ok_lo && ok_hi;
        push_entry.pos0  = cnt0[7:0];
        push_entry.last0 = (cnt0 + 9'd1) == eff_target;
        push_entry.pos1  = 8'(cnt0 + 9'd1);
        push_entry.last1 = (cnt0 + 9'd2) == eff_target;
        push_entry.coef1 = small_coef(hi);
        if (ok_word)
        begin
            push_entry.coef0 = {1'b0, word};
        end
        else if (ok_lo)
        begin
            push_entry.coef0 = small_coef(lo);
        end
        else
        begin
            push_entry.coef0 = small_coef(hi);
        end

        count_next = cnt0 + {7'd0, n_emit};
        if (buffer_end)
        begin
            phase_next = 2'd0;
            pw_next    = 16'd0;
        end
    end

    assign push = accept && (n_emit != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RESET;
            modulus_reg <= MODULUS_RESET;
            target_reg  <= TARGET_RESET;
            count_reg   <= 9'd0;
            phase_reg   <= 2'd0;
            pw_reg      <= 16'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MODE:    mode_reg    <= cfg_data[0];
                    CFG_MODULUS: modulus_reg <= cfg_data;
                    CFG_TARGET:  target_reg  <= cfg_data[8:0];
                    default:     ;
                endcase
            end
            if (accept)
            begin
                count_reg <= count_next;
                phase_reg <= phase_next;
                pw_reg    <= pw_next;
            end
        end
    end

endmodule

FILE: hw/rtl/lcrs_queue.sv
// Two-entry queue between the front and back parts of the sampler.
// Entries are registers; uses lcrs_pkg for the entry type.
module lcrs_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lcrs_pkg::lcrs_entry_t push_entry,
    input  logic                  pop,
    output logic                  full,
    output logic                  not_empty,
    output lcrs_pkg::lcrs_entry_t head
);
    import lcrs_pkg::*;

    lcrs_entry_t mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;

    assign full      = fill_reg == 2'd2;
    assign not_empty = fill_reg != 2'd0;
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: hw/rtl/lcrs_back.sv
// Back part of the sampler: takes queue entries and issues their coefficients one per cycle
// unless the output stalls. Drives the registered output channel. Uses lcrs_pkg.
module lcrs_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  not_empty,
    input  lcrs_pkg::lcrs_entry_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [23:0]    coefficient,
    output logic [7:0]            position,
    output logic                  last
);
    import lcrs_pkg::*;

    logic               valid_reg;
    logic               sub_reg;
    logic signed [23:0] coef_reg;
    logic [7:0]         pos_reg;
    logic               last_reg;
    logic               load;
    logic               first_half;

    assign load       = not_empty && (!valid_reg || !out_stall);
    assign first_half = head.pair && !sub_reg;
    assign pop        = load && !first_half;

    assign out_valid   = valid_reg;
    assign coefficient = coef_reg;
    assign position    = pos_reg;
    assign last        = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (sub_reg)
            begin
                coef_reg <= head.coef1;
                pos_reg  <= head.pos1;
                last_reg <= head.last1;
            end
            else
            begin
                coef_reg <= head.coef0;
                pos_reg  <= head.pos0;
                last_reg <= head.last0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                sub_reg   <= first_half;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: hw/rtl/lattice_coefficient_rejection_sampler_core.sv
// Top level of the lattice coefficient rejection sampler.
// Instantiates lcrs_front, lcrs_queue and lcrs_back; uses lcrs_pkg.
//
// The input channel takes one random byte per item with its start and buffer-end flags,
// under in_valid and in_stall. The output channel gives one coefficient per item with its
// position and last flag, under out_valid and out_stall. Mode, modulus and target count are
// written through cfg_we, cfg_index and cfg_data; the user is to write them only while the
// block is idle, which the block itself does not enforce. A result goes from its accepted
// byte into a queue entry, then into the output register. Both modes take one byte per
// cycle while the queue is not full. A small-mode byte that yields two coefficients fills
// one queue entry, whose coefficients the output issues one per cycle while not stalled.
// A two-entry queue separates the front from the output register, so bytes keep flowing
// while a result waits; in_stall rises only when that queue is full.
// Reset empties the queue and output, clears the count and partial group, and loads the
// default configuration. A stalled output holds its item until it is taken.
module lattice_coefficient_rejection_sampler_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         random_byte,
    input  logic               start_req,
    input  logic               buffer_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] coefficient,
    output logic [7:0]         position,
    output logic               last
);
    import lcrs_pkg::*;

    logic        push;
    lcrs_entry_t push_entry;
    logic        pop;
    logic        q_full;
    logic        q_not_empty;
    lcrs_entry_t q_head;

    assign in_stall = q_full;

    lcrs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .q_full      (q_full),
        .random_byte (random_byte),
        .start_req   (start_req),
        .buffer_end  (buffer_end),
        .push        (push),
        .push_entry  (push_entry)
    );

    lcrs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    lcrs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .not_empty   (q_not_empty),
        .head        (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .coefficient (coefficient),
        .position    (position),
        .last        (last)
    );

endmodule
